FILE: hdl/gtpd_pkg.sv
// ----------------------------------------------------------------------------
// gtpd_pkg
// Shared types, register map, reset values and arithmetic helpers for the
// gimbal tracking PD controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtpd_pkg;

  // Payload widths of the stream channels.
  localparam int InDataWidth  = 128;
  localparam int OutDataWidth = 96;
  localparam int AddrWidth    = 5;

  // Result kinds carried on m_tuser.
  typedef enum logic {
    KIND_MOVE = 1'b0,
    KIND_STOP = 1'b1
  } kind_t;

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_D       = 3'd1,
    REG_DEAD_BAND    = 3'd2,
    REG_STEP_LIMIT   = 3'd3,
    REG_TRAVEL_LIMIT = 3'd4,
    REG_PERIOD_MS    = 3'd5,
    REG_TIMEOUT_MS   = 3'd6
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] GainPReset       = 16'd2458;
  localparam logic [15:0] GainDReset       = 16'd492;
  localparam logic [14:0] DeadBandReset    = 15'd10;
  localparam logic [14:0] StepLimitReset   = 15'd300;
  localparam logic [14:0] TravelLimitReset = 15'd3200;
  localparam logic [15:0] PeriodMsReset    = 16'd30;
  localparam logic [15:0] TimeoutMsReset   = 16'd300;

  localparam int FracBits = 12;

  // One PD step on one axis, with gains in unsigned Q4.12. Returns zero inside the deadzone,
  // otherwise the rounded (half away from zero) and clamped step.
  function automatic logic signed [15:0] pd_step(
    input logic signed [15:0] err,
    input logic signed [15:0] prev,
    input logic [15:0]        kp,
    input logic [15:0]        kd,
    input logic [14:0]        db,
    input logic [14:0]        lim
  );
    logic signed [16:0] e17;
    logic signed [16:0] diff;
    logic signed [16:0] db17;
    logic signed [16:0] kp17;
    logic signed [16:0] kd17;
    logic signed [33:0] pp;
    logic signed [33:0] dd;
    logic signed [33:0] sum;
    logic [33:0]        mag;
    logic [33:0]        rsum;
    logic [21:0]        rnd;
    logic [14:0]        m15;
    logic               in_dz;
    e17   = {err[15], err};
    diff  = e17 - {prev[15], prev};
    db17  = {2'b00, db};
    kp17  = {1'b0, kp};
    kd17  = {1'b0, kd};
    in_dz = (e17 <= db17) && (e17 >= -db17);
    pp    = kp17 * e17;
    dd    = kd17 * diff;
    sum   = pp + dd;
    mag   = sum[33] ? 34'(-sum) : 34'(sum);
    rsum  = mag + 34'(1 << (FracBits - 1));
    rnd   = rsum[33:FracBits];
    m15   = (rnd > {7'd0, lim}) ? lim : rnd[14:0];
    if (in_dz) begin
      pd_step = 16'sd0;
    end else if (sum[33]) begin
      pd_step = -$signed({1'b0, m15});
    end else begin
      pd_step = $signed({1'b0, m15});
    end
  endfunction

  // Symmetric clamp of a 17-bit sum to +-lim.
  function automatic logic signed [15:0] clamp_sym(
    input logic signed [16:0] v,
    input logic [14:0]        lim
  );
    logic signed [16:0] hi;
    logic signed [16:0] lo;
    hi = {2'b00, lim};
    lo = -hi;
    if (v > hi) begin
      clamp_sym = hi[15:0];
    end else if (v < lo) begin
      clamp_sym = lo[15:0];
    end else begin
      clamp_sym = v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gimbal_track_pd_controller.sv
// ----------------------------------------------------------------------------
// gimbal_track_pd_controller
// Turns tracking observations into yaw and pitch step commands (or stops for
// stale ones) through a per-axis PD law with deadzone, step limit and travel limit.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Transfer when                 Carries
//  -------   ---   ---------------------------   --------------------------------
//  s_*       in    s_tvalid & s_tready           one observation
//  m_*       out   m_tvalid & m_tready           one move or stop command
//  APB       in    psel & penable & pwrite       register write (reads any time)
//
//  An observation is taken into an input register, evaluated in one pass of
//  logic and, when it produces a command, placed in the result register, from
//  which it is offered on m_*. One observation is taken every cycle while
//  m_tready does not stall the result register; the tracking state written
//  by one observation is read by the next in the following cycle, and that
//  feedback loop sets the rate.
//  Reset is synchronous and active high; it restores register defaults and
//  clears all tracking state. A stall on m_tready holds the result register
//  and, once the input register is also full, drops s_tready.
//
`timescale 1ns / 1ps
`default_nettype none

module gimbal_track_pd_controller (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Observation stream.
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  // tdata, from bit 0 up: err_x[15:0], err_y[15:0], obs_seq[31:0],
  // obs_time[31:0], now_ms[31:0].
  input  wire logic [gtpd_pkg::InDataWidth-1:0]     s_tdata,
  // tuser: obs_valid.
  input  wire logic [0:0]                           s_tuser,
  // Command stream.
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  // tdata, from bit 0 up: yaw_step[15:0], pitch_step[15:0], cmd_seq[31:0],
  // cmd_time[31:0].
  output      logic [gtpd_pkg::OutDataWidth-1:0]    m_tdata,
  // tuser: kind (0 move, 1 stop).
  output      logic [0:0]                           m_tuser,
  // Configuration port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [gtpd_pkg::AddrWidth-1:0]       paddr,
  input  wire logic [31:0]                          pwdata,
  output      logic [31:0]                          prdata,
  output      logic                                 pready
);

  // Configuration registers.
  logic [15:0] gain_p;
  logic [15:0] gain_d;
  logic [14:0] dead_band;
  logic [14:0] step_limit;
  logic [14:0] travel_limit;
  logic [15:0] period_ms;
  logic [15:0] timeout_ms;

  gtpd_pkg::reg_idx_t reg_idx;
  logic               reg_write;

  assign pready    = 1'b1;
  assign reg_idx   = gtpd_pkg::reg_idx_t'(paddr[4:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= gtpd_pkg::GainPReset;
      gain_d       <= gtpd_pkg::GainDReset;
      dead_band    <= gtpd_pkg::DeadBandReset;
      step_limit   <= gtpd_pkg::StepLimitReset;
      travel_limit <= gtpd_pkg::TravelLimitReset;
      period_ms    <= gtpd_pkg::PeriodMsReset;
      timeout_ms   <= gtpd_pkg::TimeoutMsReset;
    end else if (reg_write) begin
      case (reg_idx)
        gtpd_pkg::REG_GAIN_P:       gain_p       <= pwdata[15:0];
        gtpd_pkg::REG_GAIN_D:       gain_d       <= pwdata[15:0];
        gtpd_pkg::REG_DEAD_BAND:    dead_band    <= pwdata[14:0];
        gtpd_pkg::REG_STEP_LIMIT:   step_limit   <= pwdata[14:0];
        gtpd_pkg::REG_TRAVEL_LIMIT: travel_limit <= pwdata[14:0];
        gtpd_pkg::REG_PERIOD_MS:    period_ms    <= pwdata[15:0];
        gtpd_pkg::REG_TIMEOUT_MS:   timeout_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gtpd_pkg::REG_GAIN_P:       prdata = {16'd0, gain_p};
      gtpd_pkg::REG_GAIN_D:       prdata = {16'd0, gain_d};
      gtpd_pkg::REG_DEAD_BAND:    prdata = {17'd0, dead_band};
      gtpd_pkg::REG_STEP_LIMIT:   prdata = {17'd0, step_limit};
      gtpd_pkg::REG_TRAVEL_LIMIT: prdata = {17'd0, travel_limit};
      gtpd_pkg::REG_PERIOD_MS:    prdata = {16'd0, period_ms};
      gtpd_pkg::REG_TIMEOUT_MS:   prdata = {16'd0, timeout_ms};
      default:                    prdata = 32'd0;
    endcase
  end

  // Input register. It refills whenever it is empty or its item is being
  // evaluated in this cycle.
  logic               in_full;
  logic               in_obs_valid;
  logic signed [15:0] in_err_x;
  logic signed [15:0] in_err_y;
  logic [31:0]        in_seq;
  logic [31:0]        in_time;
  logic [31:0]        in_now;

  logic advance;
  logic fire;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_full && advance;
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_obs_valid <= s_tuser[0];
      in_err_x     <= s_tdata[15:0];
      in_err_y     <= s_tdata[31:16];
      in_seq       <= s_tdata[63:32];
      in_time      <= s_tdata[95:64];
      in_now       <= s_tdata[127:96];
    end
  end

  // Tracking state.
  logic signed [15:0] yaw_prev_err;
  logic signed [15:0] pitch_prev_err;
  logic signed [15:0] yaw_position;
  logic signed [15:0] pitch_position;
  logic [31:0]        last_used_seq;
  logic [31:0]        last_stop_seq;
  logic [31:0]        last_update_time;

  // Evaluation of the item in the input register.
  logic [31:0]        age;
  logic [31:0]        since;
  logic               stale;
  logic               too_soon;
  logic               do_stop;
  logic               do_move;
  logic signed [15:0] yaw_dstep;
  logic signed [15:0] pitch_dstep;
  logic signed [15:0] yaw_position_next;
  logic signed [15:0] pitch_position_next;
  logic signed [16:0] yaw_applied;
  logic signed [16:0] pitch_applied;

  always_comb begin
    // Time differences wrap and are read as signed 32-bit values.
    age      = in_now - in_time;
    since    = in_now - last_update_time;
    stale    = $signed(age) > $signed({16'd0, timeout_ms});
    too_soon = $signed(since) < $signed({16'd0, period_ms});

    // A stale observation gives one stop per sequence number. A fresh one is
    // used only with a new sequence number and once the period has passed.
    do_stop = fire && in_obs_valid && stale && (last_stop_seq != in_seq);
    do_move = fire && in_obs_valid && !stale && (in_seq != last_used_seq) && !too_soon;

    yaw_dstep   = gtpd_pkg::pd_step(in_err_x, yaw_prev_err, gain_p, gain_d,
                                    dead_band, step_limit);
    pitch_dstep = gtpd_pkg::pd_step(in_err_y, pitch_prev_err, gain_p, gain_d,
                                    dead_band, step_limit);

    // The target is clamped to the travel limit; the step reported is the
    // one actually applied, including any pull back after a lowered limit.
    yaw_position_next   = gtpd_pkg::clamp_sym(
                            {yaw_position[15], yaw_position} + {yaw_dstep[15], yaw_dstep},
                            travel_limit);
    pitch_position_next = gtpd_pkg::clamp_sym(
                            {pitch_position[15], pitch_position}
                            + {pitch_dstep[15], pitch_dstep},
                            travel_limit);
    yaw_applied   = {yaw_position_next[15], yaw_position_next}
                    - {yaw_position[15], yaw_position};
    pitch_applied = {pitch_position_next[15], pitch_position_next}
                    - {pitch_position[15], pitch_position};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_prev_err     <= '0;
      pitch_prev_err   <= '0;
      yaw_position     <= '0;
      pitch_position   <= '0;
      last_used_seq    <= '0;
      last_stop_seq    <= '0;
      last_update_time <= '0;
    end else if (do_stop) begin
      last_stop_seq  <= in_seq;
      yaw_prev_err   <= '0;
      pitch_prev_err <= '0;
    end else if (do_move) begin
      // The error is stored as the previous one even inside the deadzone.
      yaw_prev_err     <= in_err_x;
      pitch_prev_err   <= in_err_y;
      yaw_position     <= yaw_position_next;
      pitch_position   <= pitch_position_next;
      last_used_seq    <= in_seq;
      last_stop_seq    <= '0;
      last_update_time <= in_now;
    end
  end

  // Result register. It loads whenever it is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= do_stop || do_move;
    end
  end

  always_ff @(posedge clk) begin
    if (do_stop) begin
      m_tuser <= gtpd_pkg::KIND_STOP;
      m_tdata <= {in_now, in_seq, 32'd0};
    end else if (do_move) begin
      m_tuser <= gtpd_pkg::KIND_MOVE;
      m_tdata <= {in_now, in_seq, pitch_applied[15:0], yaw_applied[15:0]};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gtpd_checker.sv
// ----------------------------------------------------------------------------
// gtpd_checker
// Port-level checks for the gimbal tracking PD controller, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtpd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [gtpd_pkg::OutDataWidth-1:0] m_tdata,
  input wire logic [0:0]                        m_tuser
);

  // A command that is not taken stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled command changed");

  // The input side only stalls behind a full, stalled result register.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // A stop request carries no motion.
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == gtpd_pkg::KIND_STOP) |-> m_tdata[31:0] == 32'd0)
    else $error("stop request with nonzero step");

  // An applied step never reaches the most negative code.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
    else $error("applied step out of range");

endmodule

bind gimbal_track_pd_controller gtpd_checker u_gtpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
